// ===== design/kslp_pkg.sv =====
// Shared widths, defaults and reset values for the key scan long press detector.
package kslp_pkg;

  localparam int SCAN_W      = 32;
  localparam int KEY_CODE_W  = 4;
  localparam int TICKS_W     = 8;

  localparam int BLINK_DIVIDE_DEF = 5;

  localparam logic [TICKS_W-1:0] LONG_PRESS_TICKS_RST = 8'd10;

endpackage

// ===== design/kslp_in_if.sv =====
// Scan word channel: valid/ready handshake carrying one raw key scan word per tick.
interface kslp_in_if;
  import kslp_pkg::*;

  logic              valid;
  logic              ready;
  logic [SCAN_W-1:0] scan_word;

  modport source (output valid, output scan_word, input ready);
  modport sink   (input valid, input scan_word, output ready);

endinterface

// ===== design/kslp_out_if.sv =====
// Result channel: valid/ready handshake carrying click, blink and key code per tick.
interface kslp_out_if;
  import kslp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  click;
  logic                  long_press;
  logic                  blink_pulse;
  logic                  key_valid;
  logic [KEY_CODE_W-1:0] key_code;

  modport source (
    output valid, output click, output long_press, output blink_pulse,
    output key_valid, output key_code, input ready
  );
  modport sink (
    input valid, input click, input long_press, input blink_pulse,
    input key_valid, input key_code, output ready
  );

endinterface

// ===== design/key_scan_long_press_detector.sv =====
// Top level: key change / long press detector with blink divider and key encoder.
//
//  channel   dir  handshake          payload
//  scan      in   valid/ready        scan_word[31:0]
//  result    out  valid/ready        click, long_press, blink_pulse, key_valid, key_code[3:0]
//  cfg       in   cfg_wr_en          cfg_wr_data[7:0] -> long_press_ticks
//
//  One scan word per cycle unless stalled; its result shows on the result register in the
//  next cycle. State (stored word, hold counter, divider) advances on each transfer.
//  A held result stalls the input only when the result register is full and not taken.
//  rst is synchronous: clears the state, the result valid and sets long_press_ticks to 10.
module key_scan_long_press_detector #(
  parameter int BLINK_DIVIDE = kslp_pkg::BLINK_DIVIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  kslp_in_if.sink                      scan,
  kslp_out_if.source                   result,
  input  logic                         cfg_wr_en,
  input  logic [kslp_pkg::TICKS_W-1:0] cfg_wr_data
);
  import kslp_pkg::*;

  localparam int                BLINK_W    = $clog2(BLINK_DIVIDE);
  localparam logic [BLINK_W-1:0] BLINK_LAST = BLINK_W'(BLINK_DIVIDE - 1);
  localparam logic [7:0]        LOW_MASK   = 8'h06;
  localparam logic [7:0]        HIGH_MASK  = 8'h44;

  logic [SCAN_W-1:0]     last_keys;
  logic [TICKS_W-1:0]    hold_count;
  logic [BLINK_W-1:0]    blink_count;
  logic [TICKS_W-1:0]    long_press_ticks;
  logic                  out_valid;
  logic                  out_click;
  logic                  out_long;
  logic                  out_blink;
  logic                  out_key_valid;
  logic [KEY_CODE_W-1:0] out_key_code;

  logic [TICKS_W-1:0]    hold_count_next;
  logic [TICKS_W-1:0]    hold_inc;
  logic [BLINK_W-1:0]    blink_count_next;
  logic                  click_next;
  logic                  long_next;
  logic                  blink_next;
  logic                  key_valid_next;
  logic [KEY_CODE_W-1:0] key_code_next;
  logic                  xfer_in;

  function automatic logic [KEY_CODE_W-1:0] encode_key(input logic [SCAN_W-1:0] w);
    logic [KEY_CODE_W-1:0] base;
    logic [7:0]            val;
    base = '0;
    val  = '0;
    priority if (w[31:24] != 8'h00) begin
      base = 4'd0;
      val  = w[31:24];
    end else if (w[23:16] != 8'h00) begin
      base = 4'd2;
      val  = w[23:16];
    end else if (w[15:8] != 8'h00) begin
      base = 4'd4;
      val  = w[15:8];
    end else if (w[7:0] != 8'h00) begin
      base = 4'd6;
      val  = w[7:0];
    end else begin
      base = 4'd0;
      val  = 8'h00;
    end
    if ((val & LOW_MASK) != 8'h00)  base = base | 4'd1;
    if ((val & HIGH_MASK) != 8'h00) base = base | 4'd8;
    return base;
  endfunction

  // Accept while the result register is empty or being drained this cycle.
  assign scan.ready = !out_valid || result.ready;
  assign xfer_in    = scan.valid && scan.ready;

  always_comb begin
    hold_inc        = hold_count + 8'd1;
    hold_count_next = hold_count;
    click_next      = 1'b0;
    long_next       = 1'b0;
    if (scan.scan_word != last_keys) begin
      click_next      = 1'b1;
      hold_count_next = (scan.scan_word != '0) ? 8'd1 : 8'd0;
    end else if (scan.scan_word != '0 && hold_count != '0) begin
      // advance; fire and disable on reaching the configured count
      if (hold_inc == long_press_ticks) begin
        hold_count_next = '0;
        click_next      = 1'b1;
        long_next       = 1'b1;
      end else begin
        hold_count_next = hold_inc;
      end
    end

    if (blink_count == BLINK_LAST) begin
      blink_count_next = '0;
      blink_next       = 1'b1;
    end else begin
      blink_count_next = blink_count + BLINK_W'(1);
      blink_next       = 1'b0;
    end

    key_valid_next = (scan.scan_word != '0);
    key_code_next  = encode_key(scan.scan_word);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_keys        <= '0;
      hold_count       <= '0;
      blink_count      <= '0;
      long_press_ticks <= LONG_PRESS_TICKS_RST;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr_en) long_press_ticks <= cfg_wr_data;
      if (xfer_in) begin
        last_keys   <= scan.scan_word;
        hold_count  <= hold_count_next;
        blink_count <= blink_count_next;
        out_valid   <= 1'b1;
      end else if (result.ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  // Result payload: load on each input transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (xfer_in) begin
      out_click     <= click_next;
      out_long      <= long_next;
      out_blink     <= blink_next;
      out_key_valid <= key_valid_next;
      out_key_code  <= key_code_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.click       = out_click;
  assign result.long_press  = out_long;
  assign result.blink_pulse = out_blink;
  assign result.key_valid   = out_key_valid;
  assign result.key_code    = out_key_code;

endmodule
